[rtl/core/refcounted_mac_table_defines.svh]
// assertion macros used by the checker file
`ifndef REFCOUNTED_MAC_TABLE_DEFINES_SVH
`define REFCOUNTED_MAC_TABLE_DEFINES_SVH

// condition holds in the same cycle as the trigger
`define RMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define RMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rmt_pkg.sv]
`default_nettype none

package rmt_pkg;

  typedef enum logic [2:0] {
    REQ_ACQUIRE   = 3'd0,
    REQ_FIND      = 3'd1,
    REQ_READ      = 3'd2,
    REQ_RELEASE   = 3'd3,
    REQ_NEXT_USED = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOKUP,
    S_WALK,
    S_FINISH,
    S_MISS,
    S_NOTFOUND
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  index_out;
    logic [47:0] mac_out;
    logic [15:0] ref_count_out;
    logic [4:0]  total_used;
    logic        program_slot;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic read;
    logic step;
    logic lookup;
    logic finish;
    logic miss;
    logic notfound;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       idx_ok;
    logic       start_ok;
    logic       hit;
    logic       scan_end;
    logic       ptr_done;
    logic       walk_hit;
    logic       walk_end;
    logic       out_free;
  } ctrl_stat_t;

endpackage

`default_nettype wire

[rtl/core/rmt_if.sv]
`default_nettype none

interface rmt_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [47:0] mac;
  logic [7:0]  index;
  logic        scan_from_start;

  modport source (output valid, req_type, mac, index, scan_from_start, input ready);
  modport sink (input valid, req_type, mac, index, scan_from_start, output ready);
endinterface

interface rmt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  index_out;
  logic [47:0] mac_out;
  logic [15:0] ref_count_out;
  logic [4:0]  total_used;
  logic        program_slot;

  modport source (output valid, status, index_out, mac_out, ref_count_out, total_used,
                  program_slot, input ready);
  modport sink (input valid, status, index_out, mac_out, ref_count_out, total_used,
                program_slot, output ready);
endinterface

`default_nettype wire

[rtl/core/rmt_ctrl.sv]
`default_nettype none

module rmt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmt_pkg::ctrl_stat_t stat,
  output rmt_pkg::ctrl_cmd_t  cmd
);

  rmt_pkg::state_t state;
  rmt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rmt_pkg::S_IDLE: begin
        if (in_valid) state_next = rmt_pkg::S_DISPATCH;
      end
      rmt_pkg::S_DISPATCH: begin
        unique case (stat.op) inside
          rmt_pkg::REQ_ACQUIRE, rmt_pkg::REQ_FIND: begin
            state_next = rmt_pkg::S_LOOKUP;
          end
          rmt_pkg::REQ_READ, rmt_pkg::REQ_RELEASE: begin
            state_next = stat.idx_ok ? rmt_pkg::S_FINISH : rmt_pkg::S_NOTFOUND;
          end
          rmt_pkg::REQ_NEXT_USED: begin
            state_next = stat.start_ok ? rmt_pkg::S_WALK : rmt_pkg::S_NOTFOUND;
          end
          default: begin
            state_next = rmt_pkg::S_NOTFOUND;
          end
        endcase
      end
      rmt_pkg::S_LOOKUP: begin
        if (stat.hit) state_next = rmt_pkg::S_FINISH;
        else if (stat.scan_end) state_next = rmt_pkg::S_MISS;
      end
      rmt_pkg::S_WALK: begin
        if (stat.walk_hit) state_next = rmt_pkg::S_FINISH;
        else if (stat.walk_end) state_next = rmt_pkg::S_NOTFOUND;
      end
      rmt_pkg::S_FINISH, rmt_pkg::S_MISS, rmt_pkg::S_NOTFOUND: begin
        if (stat.out_free) state_next = rmt_pkg::S_IDLE;
      end
      default: begin
        state_next = rmt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      rmt_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rmt_pkg::S_DISPATCH: begin
        cmd.read = stat.idx_ok &&
                   (stat.op == rmt_pkg::REQ_READ || stat.op == rmt_pkg::REQ_RELEASE);
      end
      rmt_pkg::S_LOOKUP: begin
        cmd.lookup = 1'b1;
        // hold the read register once the matching slot sits in it or the last slot was read
        cmd.read   = !stat.ptr_done && !stat.hit;
      end
      rmt_pkg::S_WALK: begin
        cmd.read = stat.walk_hit;
        cmd.step = !stat.walk_hit && !stat.walk_end;
      end
      rmt_pkg::S_FINISH: begin
        cmd.finish = stat.out_free;
      end
      rmt_pkg::S_MISS: begin
        cmd.miss = stat.out_free;
      end
      rmt_pkg::S_NOTFOUND: begin
        cmd.notfound = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/rmt_datapath.sv]
`default_nettype none

module rmt_datapath #(
  parameter int ENTRIES  = 16,
  parameter int REF_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  rmt_pkg::ctrl_cmd_t  cmd,
  output rmt_pkg::ctrl_stat_t stat,
  input  logic [2:0]          in_req_type,
  input  logic [47:0]         in_mac,
  input  logic [7:0]          in_index,
  input  logic                in_scan_from_start,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output rmt_pkg::rsp_t       rsp_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam int UW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;
  localparam logic [8:0] ENTRIES_W = 9'(ENTRIES);

  // slot store, one read and one write per cycle
  logic [47:0]         mem_mac  [ENTRIES];
  logic [REF_BITS-1:0] mem_refs [ENTRIES];

  logic [ENTRIES-1:0]  slot_valid;
  logic [UW-1:0]       used_count;
  logic [UW-1:0]       used_next;

  logic [2:0]          req_op;
  logic [47:0]         req_mac;
  logic [7:0]          req_index;
  logic                req_from_start;

  logic [IW-1:0]       ptr;
  logic [IW-1:0]       ptr_init;
  logic                ptr_done;
  logic                live;
  logic                rd_vld;
  logic [IW-1:0]       rd_idx;
  logic [47:0]         rd_mac;
  logic [REF_BITS-1:0] rd_refs;
  logic                have_free;
  logic [IW-1:0]       free_idx;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [47:0]         wmac;
  logic [REF_BITS-1:0] wrefs;
  logic                set_valid;
  logic                clr_valid;
  logic [REF_BITS-1:0] refs_inc;
  logic [REF_BITS-1:0] refs_dec;
  logic                load_out;
  logic [8:0]          in_index_inc;
  rmt_pkg::rsp_t       res;

  assign in_index_inc = {1'b0, in_index} + 9'd1;

  always_comb begin
    ptr_init = '0;
    if (in_req_type == rmt_pkg::REQ_READ || in_req_type == rmt_pkg::REQ_RELEASE) begin
      ptr_init = IW'(in_index);
    end else if (in_req_type == rmt_pkg::REQ_NEXT_USED && !in_scan_from_start) begin
      ptr_init = IW'(in_index_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op         <= in_req_type;
      req_mac        <= in_mac;
      req_index      <= in_index;
      req_from_start <= in_scan_from_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      ptr_done  <= 1'b0;
      live      <= 1'b0;
      have_free <= 1'b0;
    end else if (cmd.load) begin
      ptr       <= ptr_init;
      ptr_done  <= 1'b0;
      live      <= 1'b0;
      have_free <= 1'b0;
    end else begin
      if (cmd.read) begin
        live <= 1'b1;
        if (ptr == LAST) ptr_done <= 1'b1;
        else ptr <= ptr + IW'(1);
      end else if (cmd.step) begin
        ptr <= ptr + IW'(1);
      end
      // lowest empty slot seen during the lookup
      if (cmd.lookup && live && !rd_vld && !have_free) begin
        have_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup && live && !rd_vld && !have_free) begin
      free_idx <= rd_idx;
    end
    if (cmd.read) begin
      rd_mac  <= mem_mac[ptr];
      rd_refs <= mem_refs[ptr];
      rd_idx  <= ptr;
      rd_vld  <= slot_valid[ptr];
    end
    if (we) begin
      mem_mac[waddr]  <= wmac;
      mem_refs[waddr] <= wrefs;
    end
  end

  assign stat.op       = req_op;
  assign stat.idx_ok   = ({1'b0, req_index} < ENTRIES_W) && slot_valid[req_index[IW-1:0]];
  assign stat.start_ok = req_from_start || (({1'b0, req_index} + 9'd1) < ENTRIES_W);
  assign stat.hit      = live && rd_vld && (rd_mac == req_mac);
  assign stat.scan_end = live && (rd_idx == LAST);
  assign stat.ptr_done = ptr_done;
  assign stat.walk_hit = slot_valid[ptr];
  assign stat.walk_end = (ptr == LAST);
  assign stat.out_free = !rsp_valid || rsp_ready;

  assign refs_inc = rd_refs + REF_BITS'(1);
  assign refs_dec = (rd_refs != '0) ? rd_refs - REF_BITS'(1) : '0;

  always_comb begin
    we        = 1'b0;
    waddr     = rd_idx;
    wmac      = rd_mac;
    wrefs     = rd_refs;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    used_next = used_count;
    res.status        = rmt_pkg::ST_NOT_FOUND;
    res.index_out     = '0;
    res.mac_out       = '0;
    res.ref_count_out = '0;
    res.program_slot  = 1'b0;
    if (cmd.finish) begin
      res.status        = rmt_pkg::ST_OK;
      res.index_out     = 4'(rd_idx);
      res.mac_out       = rd_mac;
      res.ref_count_out = 16'(rd_refs);
      if (req_op == rmt_pkg::REQ_ACQUIRE) begin
        if (rd_refs == REF_MAX) begin
          res.status = rmt_pkg::ST_SATURATED;
        end else begin
          we                = 1'b1;
          wrefs             = refs_inc;
          res.ref_count_out = 16'(refs_inc);
        end
      end else if (req_op == rmt_pkg::REQ_RELEASE) begin
        we                = 1'b1;
        wrefs             = refs_dec;
        res.ref_count_out = 16'(refs_dec);
        if (refs_dec == '0) begin
          clr_valid = 1'b1;
          if (used_count != '0) used_next = used_count - UW'(1);
        end
      end
    end else if (cmd.miss && req_op == rmt_pkg::REQ_ACQUIRE) begin
      if (have_free) begin
        we                = 1'b1;
        waddr             = free_idx;
        wmac              = req_mac;
        wrefs             = REF_BITS'(1);
        set_valid         = 1'b1;
        used_next         = used_count + UW'(1);
        res.status        = rmt_pkg::ST_OK;
        res.index_out     = 4'(free_idx);
        res.mac_out       = req_mac;
        res.ref_count_out = 16'd1;
        res.program_slot  = 1'b1;
      end else begin
        res.status = rmt_pkg::ST_NO_SPACE;
      end
    end
    res.total_used = 5'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      used_count <= '0;
    end else begin
      used_count <= used_next;
      if (set_valid) slot_valid[waddr] <= 1'b1;
      if (clr_valid) slot_valid[waddr] <= 1'b0;
    end
  end

  assign load_out = cmd.finish || cmd.miss || cmd.notfound;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) rsp_data <= res;
  end

endmodule

`default_nettype wire

[rtl/core/refcounted_mac_table.sv]
// channel  dir  beat contents
// req      in   req_type, mac, index, scan_from_start
// rsp      out  status, index_out, mac_out, ref_count_out, total_used, program_slot
//
// read, release, unknown request and a next-used start past the end pass from the
// dispatch state straight to the state that loads the result. acquire and find
// scan the slot store from entry 0 through its single read port, and next used
// walks the valid bits from its start, both at one entry per cycle.
// reset clears the valid bits, the used count and the controller; the slot store
// itself is not cleared. req is ready only between requests; a result still held
// in the output register stalls only the last step of the following request.
`default_nettype none

module refcounted_mac_table #(
  parameter int ENTRIES  = 16,
  parameter int REF_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  rmt_req_if.sink    req,
  rmt_rsp_if.source  rsp
);

  rmt_pkg::ctrl_cmd_t  cmd;
  rmt_pkg::ctrl_stat_t stat;
  rmt_pkg::rsp_t       rsp_data;
  logic                rsp_valid;

  rmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rmt_datapath #(
    .ENTRIES  (ENTRIES),
    .REF_BITS (REF_BITS)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .in_req_type        (req.req_type),
    .in_mac             (req.mac),
    .in_index           (req.index),
    .in_scan_from_start (req.scan_from_start),
    .rsp_valid          (rsp_valid),
    .rsp_ready          (rsp.ready),
    .rsp_data           (rsp_data)
  );

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_data.status;
  assign rsp.index_out     = rsp_data.index_out;
  assign rsp.mac_out       = rsp_data.mac_out;
  assign rsp.ref_count_out = rsp_data.ref_count_out;
  assign rsp.total_used    = rsp_data.total_used;
  assign rsp.program_slot  = rsp_data.program_slot;

endmodule

`default_nettype wire

[rtl/core/rmt_checker.sv]
`default_nettype none

`include "refcounted_mac_table_defines.svh"

module rmt_checker #(
  parameter int ENTRIES = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [3:0]  index_out,
  input logic [47:0] mac_out,
  input logic [15:0] ref_count_out,
  input logic [4:0]  total_used,
  input logic        program_slot
);

  // a stalled result beat keeps its contents
  `RMT_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(status) && $stable(index_out) && $stable(mac_out) &&
    $stable(ref_count_out) && $stable(total_used) && $stable(program_slot),
    "result beat changed while stalled")

  // one request at a time: no second beat straight after an accepted one
  `RMT_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready,
    "request taken while another is in progress")

  // failed lookups and allocations report an empty slot
  `RMT_ASSERT_SAME(a_empty_fail, clk, rst,
    rsp_valid && (status == rmt_pkg::ST_NOT_FOUND || status == rmt_pkg::ST_NO_SPACE),
    index_out == '0 && mac_out == '0 && ref_count_out == '0 && !program_slot,
    "failure result carries slot data")

  // no space only when every slot is occupied
  `RMT_ASSERT_SAME(a_full_table, clk, rst,
    rsp_valid && status == rmt_pkg::ST_NO_SPACE, total_used == 5'(ENTRIES),
    "no space reported with free slots")

endmodule

bind refcounted_mac_table rmt_checker #(
  .ENTRIES (ENTRIES)
) u_rmt_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .index_out     (rsp.index_out),
  .mac_out       (rsp.mac_out),
  .ref_count_out (rsp.ref_count_out),
  .total_used    (rsp.total_used),
  .program_slot  (rsp.program_slot)
);

`default_nettype wire
